// ===== design/lowest_free_id_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top_macros
// assertion helpers for the identifier allocator
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define LFIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfia_pkg.sv =====
// ----------------------------------------------------------------------------
// lfia_pkg
// shared types, constants and helper functions of the identifier allocator
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int CAPACITY  = 1024;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = CAPACITY / WORD_W;
    localparam int WORD_AW   = $clog2(NUM_WORDS);
    localparam int BIT_AW    = $clog2(WORD_W);
    localparam int ID_W      = 10;
    localparam int GRANT_W   = 11;
    localparam int POOL_W    = 11;

    localparam logic [POOL_W-1:0]  POOL_MAX   = POOL_W'(CAPACITY);
    localparam logic [GRANT_W-1:0] GRANT_NONE = {GRANT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_CHECK   = 2'd1,
        REQ_RELEASE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } t_cmd;

    // index of the lowest set bit, zero when none is set
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_AW-1:0] res;
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = BIT_AW'(i);
            end
        end
        return res;
    endfunction

    // same for the per-word summary
    function automatic logic [WORD_AW-1:0] lowest_word(input logic [NUM_WORDS-1:0] v);
        logic [WORD_AW-1:0] res;
        res = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = WORD_AW'(i);
            end
        end
        return res;
    endfunction

    // word contents right after a fill with the given limit
    function automatic logic [WORD_W-1:0] fill_word(input logic [POOL_W-1:0] limit,
                                                    input logic [WORD_AW-1:0] idx);
        logic [POOL_W-BIT_AW-1:0] hi;
        logic [POOL_W-BIT_AW-1:0] wi;
        logic [WORD_W-1:0]        res;
        hi = limit[POOL_W-1:BIT_AW];
        wi = (POOL_W-BIT_AW)'(idx);
        if (hi > wi) begin
            res = '1;
        end else if (hi == wi) begin
            res = (WORD_W'(1) << limit[BIT_AW-1:0]) - WORD_W'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // summary bits right after a fill with the given limit
    function automatic logic [NUM_WORDS-1:0] fill_summary(input logic [POOL_W-1:0] limit);
        logic [NUM_WORDS-1:0] res;
        for (int i = 0; i < NUM_WORDS; i++) begin
            res[i] = |fill_word(limit, WORD_AW'(i));
        end
        return res;
    endfunction

endpackage

// ===== design/lfia_ram.sv =====
// ----------------------------------------------------------------------------
// lfia_ram
// simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
module lfia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lfia_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfia_ctrl
// request sequencer: accept, read bitmap word, execute
// ----------------------------------------------------------------------------
module lfia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output lfia_pkg::t_cmd o_cmd
);

    lfia_pkg::t_state r_state;
    lfia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfia_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfia_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lfia_pkg::ST_READ;
                end
            end
            lfia_pkg::ST_READ: n_state = lfia_pkg::ST_EXEC;
            lfia_pkg::ST_EXEC: n_state = lfia_pkg::ST_IDLE;
            default:           n_state = lfia_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            lfia_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            lfia_pkg::ST_READ: o_cmd.rd   = 1'b1;
            lfia_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            default:           busy       = 1'b1;
        endcase
    end

endmodule

// ===== design/lfia_dpath.sv =====
// ----------------------------------------------------------------------------
// lfia_dpath
// two-level free bitmap: summary flops over a word memory with valid bits
// ----------------------------------------------------------------------------
module lfia_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfia_pkg::POOL_W-1:0]     i_cfg_data,
    input  lfia_pkg::t_cmd                  i_cmd,
    input  logic [1:0]                      i_req_type,
    input  logic [lfia_pkg::ID_W-1:0]       i_id_number,
    output logic signed [lfia_pkg::GRANT_W-1:0] o_granted_id,
    output logic                            o_is_free,
    output logic                            o_strobe
);

    logic [1:0]                      r_req;
    logic [lfia_pkg::WORD_AW-1:0]    r_word;
    logic [lfia_pkg::BIT_AW-1:0]     r_bit;
    logic                            r_empty;
    logic [lfia_pkg::POOL_W-1:0]     r_limit;
    logic [lfia_pkg::NUM_WORDS-1:0]  r_valid;
    logic [lfia_pkg::NUM_WORDS-1:0]  r_summary;
    logic [lfia_pkg::GRANT_W-1:0]    r_granted;
    logic                            r_is_free;
    logic                            r_strobe;

    logic [lfia_pkg::WORD_W-1:0]     rdata;
    logic [lfia_pkg::WORD_W-1:0]     cur_word;
    logic [lfia_pkg::WORD_W-1:0]     new_word;
    logic [lfia_pkg::WORD_W-1:0]     onehot;
    logic [lfia_pkg::BIT_AW-1:0]     bit_sel;
    logic                            is_get;
    logic                            is_check;
    logic                            is_release;
    logic                            we;
    logic [lfia_pkg::POOL_W-1:0]     cfg_limit;

    lfia_ram #(
        .WIDTH (lfia_pkg::WORD_W),
        .DEPTH (lfia_pkg::NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_word),
        .i_wdata (new_word),
        .i_re    (i_cmd.rd),
        .i_raddr (r_word),
        .o_rdata (rdata)
    );

    assign is_get     = (r_req == lfia_pkg::REQ_GET);
    assign is_check   = (r_req == lfia_pkg::REQ_CHECK);
    assign is_release = (r_req == lfia_pkg::REQ_RELEASE);

    assign cfg_limit = (i_cfg_data > lfia_pkg::POOL_MAX) ? lfia_pkg::POOL_MAX : i_cfg_data;

    always_comb begin
        cur_word = r_valid[r_word] ? rdata : lfia_pkg::fill_word(r_limit, r_word);
        bit_sel  = is_get ? lfia_pkg::lowest_set(cur_word) : r_bit;
        onehot   = lfia_pkg::WORD_W'(1) << bit_sel;
        new_word = is_get ? (cur_word & ~onehot) : (cur_word | onehot);
        we       = i_cmd.exec && ((is_get && !r_empty) || is_release);
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_empty <= ~|r_summary;
            if (i_req_type == lfia_pkg::REQ_GET) begin
                r_word <= lfia_pkg::lowest_word(r_summary);
                r_bit  <= '0;
            end else begin
                r_word <= i_id_number[lfia_pkg::ID_W-1:lfia_pkg::BIT_AW];
                r_bit  <= i_id_number[lfia_pkg::BIT_AW-1:0];
            end
        end
    end

    // bitmap bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= lfia_pkg::POOL_MAX;
            r_valid   <= '0;
            r_summary <= lfia_pkg::fill_summary(lfia_pkg::POOL_MAX);
        end else if (i_cfg_we) begin
            r_limit   <= cfg_limit;
            r_valid   <= '0;
            r_summary <= lfia_pkg::fill_summary(cfg_limit);
        end else if (we) begin
            r_valid[r_word]   <= 1'b1;
            r_summary[r_word] <= |new_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_get) begin
                r_granted <= r_empty ? lfia_pkg::GRANT_NONE
                                     : lfia_pkg::GRANT_W'({r_word, bit_sel});
            end else begin
                r_granted <= '0;
            end
            r_is_free <= is_check && cur_word[r_bit];
        end
    end

    assign o_granted_id = r_granted;
    assign o_is_free    = r_is_free;
    assign o_strobe     = r_strobe;

endmodule

// ===== design/lowest_free_id_allocator_top.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top
// lowest-first identifier allocator over a two-level free bitmap
// ----------------------------------------------------------------------------
// Each request goes through these steps in order: the accepting cycle
// picks the bitmap word, the READ state does the registered read of the
// word memory, and the EXEC state finds the bit and writes the word back.
// busy falls in the cycle the result is shown, so a new request is taken
// only once the last one is through. o_strobe is high for a single cycle;
// the receiver cannot stall it and must take it while o_strobe is high. A
// write of the pool size takes effect at once and needs no clearing pass.
module lowest_free_id_allocator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfia_pkg::POOL_W-1:0]         i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [lfia_pkg::ID_W-1:0]           i_id_number,
    output logic                                o_strobe,
    output logic signed [lfia_pkg::GRANT_W-1:0] o_granted_id,
    output logic                                o_is_free
);

`include "lowest_free_id_allocator_top_macros.svh"

    lfia_pkg::t_cmd cmd;

    lfia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    lfia_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_id_number  (i_id_number),
        .o_granted_id (o_granted_id),
        .o_is_free    (o_is_free),
        .o_strobe     (o_strobe)
    );

    `LFIA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after request")
    `LFIA_ASSERT_NOW(a_result_latency, i_clk, i_rst_n, start && !busy, ##3 o_strobe, "result strobe missing")
    `LFIA_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")
    `LFIA_ASSERT_NOW(a_result_excl, i_clk, i_rst_n, o_strobe && o_is_free, o_granted_id == 0, "check result carries an id")

endmodule
